// ===== rtl/core/radar_polar_point_extractor_defines.svh =====
// Assertion macros for the polar point extractor checker.
// Depends on nothing; included by the checker file only.
`ifndef RADAR_POLAR_POINT_EXTRACTOR_DEFINES_SVH
`define RADAR_POLAR_POINT_EXTRACTOR_DEFINES_SVH

// plain property, sampled on clk, off while reset is low
`define RPPE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// a stalled transaction keeps valid and the named signal
`define RPPE_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		((vld) && !(rdy) |=> (vld) && $stable(sig))) else $error(msg);

`endif

// ===== rtl/core/rppe_pkg.sv =====
// Shared types, constants and the quarter-wave sine table of the point extractor.
// No dependencies; imported by every module of the block.
package rppe_pkg;

	localparam int AZ_COUNT        = 400;
	localparam int MAX_BINS        = 4096;
	localparam int TRIG_BITS       = 16;
	localparam int FRAC            = TRIG_BITS - 1;
	localparam int QUARTER         = AZ_COUNT / 4;
	localparam int QTR_W           = $clog2(QUARTER + 1);

	localparam int ANGLE_W = 16;
	localparam int BIN_W   = 12;
	localparam int BND_W   = 13;
	localparam int POW_W   = 8;
	localparam int AZ_W    = 9;
	localparam int LEN_W   = 16;
	localparam int CNT_W   = $clog2(ANGLE_W);
	localparam int RAD_W   = BIN_W + LEN_W;
	localparam int PROD_W  = RAD_W + FRAC;
	localparam int POS_W   = 29;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 16;

	localparam logic [AZ_W-1:0]  AZ_MAX   = AZ_W'(AZ_COUNT - 1);
	localparam logic [AZ_W:0]    AZ_N     = (AZ_W + 1)'(AZ_COUNT);
	localparam logic [BND_W-1:0] BIN_LIMIT = BND_W'(MAX_BINS);

	typedef enum logic [IDX_W-1:0] {
		REG_ENCODER_STEP  = 3'd0,
		REG_FIRST_AZIMUTH = 3'd1,
		REG_LAST_AZIMUTH  = 3'd2,
		REG_FIRST_BIN     = 3'd3,
		REG_BIN_BOUND     = 3'd4,
		REG_POWER_LIMIT   = 3'd5,
		REG_ANGLE_OFFSET  = 3'd6,
		REG_BIN_LENGTH    = 3'd7
	} cfg_reg_e;

	typedef struct packed {
		logic [ANGLE_W-1:0] encoder_step;
		logic [AZ_W-1:0]    first_azimuth;
		logic [AZ_W-1:0]    last_azimuth_bound;
		logic [BND_W-1:0]   first_bin;
		logic [BND_W-1:0]   bin_bound;
		logic [POW_W-1:0]   power_limit;
		logic [AZ_W-1:0]    angle_offset;
		logic [LEN_W-1:0]   bin_length;
	} cfg_t;

	// one classified sample handed from front to back
	typedef struct packed {
		logic             point_valid;
		logic             frame_end;
		logic [AZ_W-1:0]  azimuth;
		logic [BIN_W-1:0] bin;
		logic [POW_W-1:0] power;
	} entry_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_DIV,
		FS_CLASSIFY
	} front_state_t;

	typedef logic [FRAC-1:0] sin_rom_t [0:QUARTER];

	// sin(pi/2 * j / QUARTER) in unsigned Q0.FRAC, half up, saturated below 1.0
	function automatic sin_rom_t build_sin_rom();
		sin_rom_t    rom;
		real         v;
		logic [31:0] m;
		for (int j = 0; j <= QUARTER; j++) begin
			v = $sin(1.57079632679489661923 * j / QUARTER) * (2.0 ** FRAC);
			m = 32'($rtoi(v + 0.5));
			if (m > 32'((2 ** FRAC) - 1))
				m = 32'((2 ** FRAC) - 1);
			rom[j] = m[FRAC-1:0];
		end
		return rom;
	endfunction

	localparam sin_rom_t SIN_ROM = build_sin_rom();

endpackage

// ===== rtl/core/rppe_front.sv =====
// Front end: takes samples, finds the azimuth index with a bit-serial divider,
// applies the windows and rotation check, pushes classified entries. Uses rppe_pkg.
module rppe_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rppe_pkg::cfg_t             cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rppe_pkg::ANGLE_W-1:0] encoder_angle,
	input  logic [rppe_pkg::BIN_W-1:0] bin_number,
	input  logic [rppe_pkg::POW_W-1:0] power,
	input  logic                       line_end,
	output logic                       push,
	input  logic                       push_ready,
	output rppe_pkg::entry_t           push_entry
);
	import rppe_pkg::*;

	front_state_t       state_q, state_d;
	logic [ANGLE_W-1:0] dq_q;
	logic [ANGLE_W-1:0] rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [BIN_W-1:0]   bin_q;
	logic [POW_W-1:0]   power_q;
	logic               last_q;
	logic [AZ_W-1:0]    prev_az_q;

	logic [ANGLE_W:0]   trial;
	logic               ge;
	logic [ANGLE_W:0]   diff;
	logic [AZ_W-1:0]    idx;
	logic [AZ_W-1:0]    off;
	logic [AZ_W:0]      adj_sum;
	logic [AZ_W-1:0]    adj;
	logic [BND_W-1:0]   bbound;
	logic               hit;
	logic               wrap;
	logic               emit;
	logic               retire;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, dq_q[ANGLE_W-1]};
	assign ge    = trial >= {1'b0, cfg.encoder_step};
	assign diff  = trial - {1'b0, cfg.encoder_step};

	assign idx = (dq_q > ANGLE_W'(AZ_MAX)) ? AZ_MAX : dq_q[AZ_W-1:0];
	assign off = (cfg.angle_offset > AZ_W'(AZ_COUNT)) ?
		AZ_W'(AZ_COUNT) : cfg.angle_offset;
	assign adj_sum = {1'b0, idx} + {1'b0, off};
	assign adj = (adj_sum >= AZ_N) ? AZ_W'(adj_sum - AZ_N) : adj_sum[AZ_W-1:0];
	assign bbound = (cfg.bin_bound > BIN_LIMIT) ? BIN_LIMIT : cfg.bin_bound;

	assign hit = (idx >= cfg.first_azimuth) && (idx < cfg.last_azimuth_bound) &&
		({1'b0, bin_q} >= cfg.first_bin) && ({1'b0, bin_q} < bbound) &&
		(power_q > cfg.power_limit);
	assign wrap = last_q && (idx < prev_az_q);
	assign emit = hit || wrap;

	assign push_entry.point_valid = hit;
	assign push_entry.frame_end   = wrap;
	assign push_entry.azimuth     = adj;
	assign push_entry.bin         = bin_q;
	assign push_entry.power       = power_q;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		push     = 1'b0;
		retire   = 1'b0;
		unique case (state_q)
			FS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = FS_DIV;
			end
			FS_DIV: begin
				if (cnt_q == CNT_W'(ANGLE_W - 1))
					state_d = FS_CLASSIFY;
			end
			FS_CLASSIFY: begin
				push = emit;
				if (!emit || push_ready) begin
					retire  = 1'b1;
					state_d = FS_IDLE;
				end
			end
			default: state_d = FS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FS_IDLE;
			prev_az_q <= '0;
		end else begin
			state_q <= state_d;
			if (retire && last_q)
				prev_az_q <= idx;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dq_q    <= encoder_angle;
			rem_q   <= '0;
			cnt_q   <= '0;
			bin_q   <= bin_number;
			power_q <= power;
			last_q  <= line_end;
		end else if (state_q == FS_DIV) begin
			dq_q  <= {dq_q[ANGLE_W-2:0], ge};
			rem_q <= ge ? diff[ANGLE_W-1:0] : trial[ANGLE_W-1:0];
			cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

// ===== rtl/core/rppe_queue.sv =====
// Two-entry queue between front and back end.
// Uses rppe_pkg for the entry type.
module rppe_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             push_ready,
	input  rppe_pkg::entry_t push_entry,
	output logic             pop_valid,
	input  logic             pop,
	output rppe_pkg::entry_t pop_entry
);
	import rppe_pkg::*;

	entry_t     mem_q [0:1];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_entry  = mem_q[rd_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= ~wr_q;
			if (do_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_entry;
	end

endmodule

// ===== rtl/core/rppe_back.sv =====
// Back end: radius, sine table lookup, scaling and rounding to 0.1 mm, output register.
// Uses rppe_pkg (types, sine table).
module rppe_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [rppe_pkg::LEN_W-1:0]   bin_length,
	input  logic                         pop_valid,
	output logic                         pop,
	input  rppe_pkg::entry_t             pop_entry,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         point_valid,
	output logic                         frame_end,
	output logic signed [rppe_pkg::POS_W-1:0] pos_x,
	output logic signed [rppe_pkg::POS_W-1:0] pos_y,
	output logic [rppe_pkg::POW_W-1:0]   intensity,
	output logic [rppe_pkg::AZ_W-1:0]    point_azimuth,
	output logic [rppe_pkg::BIN_W-1:0]   point_bin
);
	import rppe_pkg::*;

	logic               en;
	logic [1:0]         quad;
	logic [AZ_W-1:0]    base;
	logic [QTR_W-1:0]   m;
	logic [FRAC-1:0]    sin_m;
	logic [FRAC-1:0]    cos_m;
	logic [FRAC-1:0]    cm;
	logic [FRAC-1:0]    sm;
	logic               cn;
	logic               sn;

	logic               v_s1, v_s2, v_s3;
	entry_t             e_s1, e_s2;
	logic [RAD_W-1:0]   radius_s1;
	logic [FRAC-1:0]    cm_s1, sm_s1;
	logic               cn_s1, sn_s1, cn_s2, sn_s2;
	logic [PROD_W-1:0]  px_s2, py_s2;
	logic [PROD_W:0]    rx, ry;
	logic [POS_W-1:0]   mx, my;

	assign en  = !v_s3 || out_ready;
	assign pop = pop_valid && en;

	// quadrant of the bearing; table holds the first quarter wave
	always_comb begin
		if (pop_entry.azimuth >= AZ_W'(3 * QUARTER)) begin
			quad = 2'd3;
			base = AZ_W'(3 * QUARTER);
		end else if (pop_entry.azimuth >= AZ_W'(2 * QUARTER)) begin
			quad = 2'd2;
			base = AZ_W'(2 * QUARTER);
		end else if (pop_entry.azimuth >= AZ_W'(QUARTER)) begin
			quad = 2'd1;
			base = AZ_W'(QUARTER);
		end else begin
			quad = 2'd0;
			base = '0;
		end
		m     = QTR_W'(pop_entry.azimuth - base);
		sin_m = SIN_ROM[m];
		cos_m = SIN_ROM[QTR_W'(QUARTER) - m];
		case (quad)
			2'd0: begin cm = cos_m; cn = 1'b0; sm = sin_m; sn = 1'b0; end
			2'd1: begin cm = sin_m; cn = 1'b1; sm = cos_m; sn = 1'b0; end
			2'd2: begin cm = cos_m; cn = 1'b1; sm = sin_m; sn = 1'b1; end
			default: begin cm = sin_m; cn = 1'b0; sm = cos_m; sn = 1'b1; end
		endcase
	end

	assign rx = {1'b0, px_s2} + (PROD_W + 1)'(1 << (FRAC - 1));
	assign ry = {1'b0, py_s2} + (PROD_W + 1)'(1 << (FRAC - 1));
	assign mx = rx[FRAC +: POS_W];
	assign my = ry[FRAC +: POS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= pop_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1      <= pop_entry;
			radius_s1 <= RAD_W'(pop_entry.bin) * RAD_W'(bin_length);
			cm_s1     <= cm;
			sm_s1     <= sm;
			cn_s1     <= cn;
			sn_s1     <= sn;

			e_s2  <= e_s1;
			px_s2 <= PROD_W'(radius_s1) * PROD_W'(cm_s1);
			py_s2 <= PROD_W'(radius_s1) * PROD_W'(sm_s1);
			cn_s2 <= cn_s1;
			sn_s2 <= sn_s1;

			point_valid <= e_s2.point_valid;
			frame_end   <= e_s2.frame_end;
			if (e_s2.point_valid) begin
				pos_x         <= cn_s2 ? -$signed(mx) : $signed(mx);
				pos_y         <= sn_s2 ? -$signed(my) : $signed(my);
				intensity     <= e_s2.power;
				point_azimuth <= e_s2.azimuth;
				point_bin     <= e_s2.bin;
			end else begin
				pos_x         <= '0;
				pos_y         <= '0;
				intensity     <= '0;
				point_azimuth <= '0;
				point_bin     <= '0;
			end
		end
	end

	assign out_valid = v_s3;

endmodule

// ===== rtl/core/radar_polar_point_extractor.sv =====
// Top level of the radar polar point extractor: configuration registers,
// front end, queue and back end. Uses rppe_pkg, rppe_front, rppe_queue, rppe_back.
//
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_ready  | encoder_angle, bin_number, power, line_end
// out      | out_valid / out_ready| point_valid, frame_end, pos_x, pos_y, ...
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// In the front end a sample is accepted, divided bit-serially by the encoder step,
// then classified and pushed, holding while the queue is full; only then is a new sample taken.
// The back end adds three pipeline stages up to the output register.
// A two-entry queue lets the front end keep going while the output is stalled.
// Reset is asynchronous, active low; configuration resets to the documented defaults.
module radar_polar_point_extractor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rppe_pkg::IDX_W-1:0]        cfg_index,
	input  logic [rppe_pkg::DATA_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rppe_pkg::ANGLE_W-1:0]      encoder_angle,
	input  logic [rppe_pkg::BIN_W-1:0]        bin_number,
	input  logic [rppe_pkg::POW_W-1:0]        power,
	input  logic                              line_end,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              point_valid,
	output logic                              frame_end,
	output logic signed [rppe_pkg::POS_W-1:0] pos_x,
	output logic signed [rppe_pkg::POS_W-1:0] pos_y,
	output logic [rppe_pkg::POW_W-1:0]        intensity,
	output logic [rppe_pkg::AZ_W-1:0]         point_azimuth,
	output logic [rppe_pkg::BIN_W-1:0]        point_bin
);
	import rppe_pkg::*;

	cfg_t   cfg_q;
	logic   push, push_ready, pop_valid, pop;
	entry_t push_entry, pop_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.encoder_step       <= 16'd14;
			cfg_q.first_azimuth      <= '0;
			cfg_q.last_azimuth_bound <= AZ_W'(400);
			cfg_q.first_bin          <= '0;
			cfg_q.bin_bound          <= BND_W'(4096);
			cfg_q.power_limit        <= '0;
			cfg_q.angle_offset       <= '0;
			cfg_q.bin_length         <= 16'd438;
		end else if (cfg_valid) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_ENCODER_STEP:  cfg_q.encoder_step       <= cfg_data;
				REG_FIRST_AZIMUTH: cfg_q.first_azimuth      <= cfg_data[AZ_W-1:0];
				REG_LAST_AZIMUTH:  cfg_q.last_azimuth_bound <= cfg_data[AZ_W-1:0];
				REG_FIRST_BIN:     cfg_q.first_bin          <= cfg_data[BND_W-1:0];
				REG_BIN_BOUND:     cfg_q.bin_bound          <= cfg_data[BND_W-1:0];
				REG_POWER_LIMIT:   cfg_q.power_limit        <= cfg_data[POW_W-1:0];
				REG_ANGLE_OFFSET:  cfg_q.angle_offset       <= cfg_data[AZ_W-1:0];
				REG_BIN_LENGTH:    cfg_q.bin_length         <= cfg_data;
				default: ;
			endcase
		end
	end

	rppe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.encoder_angle (encoder_angle),
		.bin_number    (bin_number),
		.power         (power),
		.line_end      (line_end),
		.push          (push),
		.push_ready    (push_ready),
		.push_entry    (push_entry)
	);

	rppe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_entry  (pop_entry)
	);

	rppe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.bin_length    (cfg_q.bin_length),
		.pop_valid     (pop_valid),
		.pop           (pop),
		.pop_entry     (pop_entry),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.point_valid   (point_valid),
		.frame_end     (frame_end),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.intensity     (intensity),
		.point_azimuth (point_azimuth),
		.point_bin     (point_bin)
	);

endmodule

// ===== rtl/core/rppe_checker.sv =====
// Port-level checks for the point extractor, bound to the top level.
// Uses rppe_pkg and radar_polar_point_extractor_defines.svh.
`include "radar_polar_point_extractor_defines.svh"

module rppe_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic                              point_valid,
	input  logic                              frame_end,
	input  logic signed [rppe_pkg::POS_W-1:0] pos_x,
	input  logic signed [rppe_pkg::POS_W-1:0] pos_y,
	input  logic [rppe_pkg::POW_W-1:0]        intensity,
	input  logic [rppe_pkg::AZ_W-1:0]         point_azimuth,
	input  logic [rppe_pkg::BIN_W-1:0]        point_bin
);
	import rppe_pkg::*;

	`RPPE_ASSERT_HOLD(a_out_hold, out_valid, out_ready, pos_x, "stalled result changed")
	`RPPE_ASSERT(a_out_reason, out_valid |-> point_valid || frame_end, "empty result transaction")
	`RPPE_ASSERT(a_out_zero, out_valid && !point_valid |-> pos_x == 0 && pos_y == 0 && intensity == 0 && point_bin == 0, "fields not cleared")
	`RPPE_ASSERT(a_az_range, out_valid && point_valid |-> point_azimuth < AZ_W'(AZ_COUNT), "point azimuth out of range")
	`RPPE_ASSERT(a_in_serial, in_valid && in_ready |=> !in_ready, "input taken while divider busy")

endmodule

bind radar_polar_point_extractor rppe_checker u_rppe_checker (.*);
